@@ sv/bpme_pkg.sv @@
// Shared types, constants and small helpers for the bin-packing move evaluator.
// No dependencies; the top level and the fitness unit refer to it by scoped names, the bench imports it.
package bpme_pkg;

  localparam int USAGE_W    = 20;
  localparam int FIT_W      = 40;
  localparam int CAP_W      = 16;
  localparam int DEM_W      = 16;
  localparam int IDX_W      = 6;
  localparam int CNT_CFG_W  = 7;
  localparam int OUT_SUM_W  = 46;
  localparam int OUT_CNT_W  = 7;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 16;

  localparam logic [USAGE_W-1:0]   USAGE_MAX = '1;
  localparam logic [OUT_SUM_W-1:0] SUM_MAX   = '1;
  localparam logic [OUT_CNT_W-1:0] COUNT_MAX = '1;

  // Register indexes on the configuration port
  localparam logic [CFG_IDX_W-1:0] REG_MACHINE_COUNT = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_FIRST_TYPE    = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_CPU_CAP_A     = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_RAM_CAP_A     = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_CPU_CAP_B     = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_RAM_CAP_B     = 3'd5;

  typedef enum logic [1:0] {
    ACT_PLACE  = 2'd0,
    ACT_REMOVE = 2'd1,
    ACT_MOVE   = 2'd2,
    ACT_NONE   = 2'd3
  } action_t;

  // One machine entry of the state memory
  typedef struct packed {
    logic [USAGE_W-1:0] cpu;
    logic [USAGE_W-1:0] ram;
    logic [FIT_W-1:0]   fit;
  } mach_t;

  localparam int MACH_W = $bits(mach_t);

  // Side data carried along the fitness pipeline
  typedef struct packed {
    logic               cand;
    logic [USAGE_W-1:0] cpu;
    logic [USAGE_W-1:0] ram;
  } fit_tag_t;

  // Capacity configuration seen by the fitness unit
  typedef struct packed {
    logic [CNT_CFG_W-1:0] first_type;
    logic [CAP_W-1:0]     cpu_a;
    logic [CAP_W-1:0]     ram_a;
    logic [CAP_W-1:0]     cpu_b;
    logic [CAP_W-1:0]     ram_b;
  } cap_t;

  function automatic logic [USAGE_W-1:0] sat_add(input logic [USAGE_W-1:0] a,
                                                 input logic [DEM_W-1:0] b);
    logic [USAGE_W:0] s;
    s = {1'b0, a} + {{(USAGE_W - DEM_W + 1){1'b0}}, b};
    return s[USAGE_W] ? USAGE_MAX : s[USAGE_W-1:0];
  endfunction

  function automatic logic [USAGE_W-1:0] clamp_sub(input logic [USAGE_W-1:0] a,
                                                   input logic [DEM_W-1:0] b);
    logic [USAGE_W-1:0] bx;
    bx = {{(USAGE_W - DEM_W){1'b0}}, b};
    return (a > bx) ? (a - bx) : '0;
  endfunction

endpackage

@@ sv/bin_packing_move_evaluator.sv @@
// Place/remove read the source entry, pass it through the fitness unit and write it back;
// a new request is taken only once the previous result has been registered. A move also
// scans the machines in use, limited by the one-read-per-cycle scan of the state RAM.
// Reset (rst_n low, synchronous) starts a clearing pass over every slot of the state RAM,
// with in_tready low; any register write then runs a refresh pass over every slot,
// also with in_tready low (none during the clearing pass).
module bin_packing_move_evaluator #(
  parameter int MACHINE_SLOTS = 64
) (
  input  logic        clk,
  input  logic        rst_n,
  // Request channel
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [39:0] in_tdata,   // machine_index[5:0], item_cpu[21:6], item_ram[37:22]
  input  logic [1:0]  in_tuser,   // action[1:0]
  // Result channel
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [63:0] out_tdata,  // dest_machine[5:0], total_fitness[51:6],
                                  // overloaded_count[58:52]
  output logic        out_tuser,  // moved[0]
  // Configuration
  input  logic        cfg_we,
  input  logic [2:0]  cfg_index,
  input  logic [15:0] cfg_wdata
);

  localparam int AW  = $clog2(MACHINE_SLOTS);
  localparam int CW  = $clog2(MACHINE_SLOTS + 1);
  localparam int NW  = (CW > bpme_pkg::CNT_CFG_W) ? CW : bpme_pkg::CNT_CFG_W;
  localparam int SW  = bpme_pkg::FIT_W + AW;
  localparam int SXW = (SW > bpme_pkg::OUT_SUM_W) ? SW : bpme_pkg::OUT_SUM_W + 1;
  localparam int CXW = (CW > bpme_pkg::OUT_CNT_W) ? CW : bpme_pkg::OUT_CNT_W + 1;
  localparam int UW  = bpme_pkg::USAGE_W;
  localparam int FW  = bpme_pkg::FIT_W;

  typedef enum logic [10:0] {
    ST_CLEAR  = 11'b000_0000_0001,
    ST_IDLE   = 11'b000_0000_0010,
    ST_RD     = 11'b000_0000_0100,
    ST_SRC    = 11'b000_0000_1000,
    ST_WAIT   = 11'b000_0001_0000,
    ST_SCAN   = 11'b000_0010_0000,
    ST_DECIDE = 11'b000_0100_0000,
    ST_WR_SRC = 11'b000_1000_0000,
    ST_WR_DST = 11'b001_0000_0000,
    ST_FIN    = 11'b010_0000_0000,
    ST_SWEEP  = 11'b100_0000_0000
  } state_t;

  state_t state_r, state_nxt;

  // Configuration registers
  logic [bpme_pkg::CNT_CFG_W-1:0] mcount_r, mcount_nxt;
  bpme_pkg::cap_t                 cap_r, cap_nxt;
  logic                           pend_r, pend_nxt;

  // Request being worked on
  bpme_pkg::action_t              act_r, act_nxt;
  logic [bpme_pkg::IDX_W-1:0]     idx_r, idx_nxt;
  logic [bpme_pkg::DEM_W-1:0]     icpu_r, icpu_nxt, iram_r, iram_nxt;

  // Source machine results
  logic [UW-1:0]                  new_cpu_r, new_cpu_nxt, new_ram_r, new_ram_nxt;
  logic [FW-1:0]                  old_fit_r, old_fit_nxt, fsrc_r, fsrc_nxt;

  // Scan / sweep bookkeeping
  logic [NW-1:0]                  rd_cnt_r, rd_cnt_nxt, res_cnt_r, res_cnt_nxt;
  logic                           rd_vld_r, rd_vld_nxt;
  logic [AW-1:0]                  rd_idx_r, rd_idx_nxt;

  // Best destination so far
  logic                           found_r, found_nxt;
  logic [FW-1:0]                  best_fit_r, best_fit_nxt;
  logic [AW-1:0]                  best_idx_r, best_idx_nxt;
  logic [UW-1:0]                  best_cpu_r, best_cpu_nxt, best_ram_r, best_ram_nxt;

  // Running totals over machines in use
  logic [SW-1:0]                  sum_r, sum_nxt;
  logic [CW-1:0]                  ovl_r, ovl_nxt;

  logic                           moved_r, moved_nxt;
  logic [bpme_pkg::IDX_W-1:0]     dest_r, dest_nxt;

  // Output register
  logic                           out_vld_r, out_vld_nxt;
  logic                           out_moved_r, out_moved_nxt;
  logic [bpme_pkg::IDX_W-1:0]     out_dest_r, out_dest_nxt;
  logic [bpme_pkg::OUT_SUM_W-1:0] out_sum_r, out_sum_nxt;
  logic [bpme_pkg::OUT_CNT_W-1:0] out_ovl_r, out_ovl_nxt;

  // RAM and fitness unit hookup
  logic                           ram_we, ram_re;
  logic [AW-1:0]                  ram_waddr, ram_raddr;
  bpme_pkg::mach_t                ram_wdata, rdat;
  logic [bpme_pkg::MACH_W-1:0]    ram_rdata;

  logic                           fit_flush, fit_req_vld, fit_res_vld;
  logic [AW-1:0]                  fit_req_idx, fit_res_idx;
  bpme_pkg::fit_tag_t             fit_req_tag, fit_res_tag;
  logic [FW-1:0]                  fit_res;

  logic [NW-1:0]                  n_act;
  logic                           accept, cfg_hit;
  logic [SXW-1:0]                 sum_ext;
  logic [CXW-1:0]                 ovl_ext;

  assign rdat = ram_rdata;

  // Machines in use, capped at the number of slots
  assign n_act = (NW'(mcount_r) > NW'(MACHINE_SLOTS)) ? NW'(MACHINE_SLOTS)
                                                       : NW'(mcount_r);

  assign in_tready = (state_r == ST_IDLE) && !pend_r;
  assign accept    = in_tvalid && in_tready;
  assign cfg_hit   = cfg_we && (cfg_index <= bpme_pkg::REG_RAM_CAP_B);

  // Widened views of the exact totals, saturated when the result is registered
  assign sum_ext = SXW'(sum_r);
  assign ovl_ext = CXW'(ovl_r);

  bpme_ram #(
    .WIDTH (bpme_pkg::MACH_W),
    .DEPTH (MACHINE_SLOTS)
  ) u_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .re    (ram_re),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  bpme_fit_unit #(
    .AW (AW)
  ) u_fit (
    .clk     (clk),
    .rst_n   (rst_n),
    .flush   (fit_flush),
    .cap     (cap_r),
    .req_vld (fit_req_vld),
    .req_idx (fit_req_idx),
    .req_tag (fit_req_tag),
    .res_vld (fit_res_vld),
    .res_idx (fit_res_idx),
    .res_tag (fit_res_tag),
    .res_fit (fit_res)
  );

  always_comb begin
    state_nxt     = state_r;
    mcount_nxt    = mcount_r;
    cap_nxt       = cap_r;
    pend_nxt      = pend_r;
    act_nxt       = act_r;
    idx_nxt       = idx_r;
    icpu_nxt      = icpu_r;
    iram_nxt      = iram_r;
    new_cpu_nxt   = new_cpu_r;
    new_ram_nxt   = new_ram_r;
    old_fit_nxt   = old_fit_r;
    fsrc_nxt      = fsrc_r;
    rd_cnt_nxt    = rd_cnt_r;
    res_cnt_nxt   = res_cnt_r;
    rd_vld_nxt    = 1'b0;
    rd_idx_nxt    = rd_idx_r;
    found_nxt     = found_r;
    best_fit_nxt  = best_fit_r;
    best_idx_nxt  = best_idx_r;
    best_cpu_nxt  = best_cpu_r;
    best_ram_nxt  = best_ram_r;
    sum_nxt       = sum_r;
    ovl_nxt       = ovl_r;
    moved_nxt     = moved_r;
    dest_nxt      = dest_r;
    out_vld_nxt   = out_vld_r && !out_tready;
    out_moved_nxt = out_moved_r;
    out_dest_nxt  = out_dest_r;
    out_sum_nxt   = out_sum_r;
    out_ovl_nxt   = out_ovl_r;

    ram_we        = 1'b0;
    ram_waddr     = '0;
    ram_wdata     = '0;
    ram_re        = 1'b0;
    ram_raddr     = '0;
    fit_flush     = 1'b0;
    fit_req_vld   = 1'b0;
    fit_req_idx   = '0;
    fit_req_tag   = '0;

    case (state_r)
      ST_CLEAR: begin
        // Zero one entry per cycle after reset
        ram_we    = 1'b1;
        ram_waddr = rd_cnt_r[AW-1:0];
        if (rd_cnt_r == NW'(MACHINE_SLOTS - 1)) begin
          rd_cnt_nxt = '0;
          state_nxt  = ST_IDLE;
        end else begin
          rd_cnt_nxt = rd_cnt_r + NW'(1);
        end
      end

      ST_IDLE: begin
        if (pend_r) begin
          pend_nxt    = 1'b0;
          rd_cnt_nxt  = '0;
          res_cnt_nxt = '0;
          sum_nxt     = '0;
          ovl_nxt     = '0;
          fit_flush   = 1'b1;
          state_nxt   = ST_SWEEP;
        end else if (accept) begin
          act_nxt   = bpme_pkg::action_t'(in_tuser);
          idx_nxt   = in_tdata[5:0];
          icpu_nxt  = in_tdata[21:6];
          iram_nxt  = in_tdata[37:22];
          moved_nxt = 1'b0;
          dest_nxt  = '0;
          state_nxt = ST_RD;
        end
      end

      ST_RD: begin
        // Out-of-range machine or unused action: report totals only
        if ((NW'(idx_r) < n_act) && (act_r != bpme_pkg::ACT_NONE)) begin
          ram_re    = 1'b1;
          ram_raddr = AW'(idx_r);
          state_nxt = ST_SRC;
        end else begin
          state_nxt = ST_FIN;
        end
      end

      ST_SRC: begin
        if (act_r == bpme_pkg::ACT_PLACE) begin
          new_cpu_nxt = bpme_pkg::sat_add(rdat.cpu, icpu_r);
          new_ram_nxt = bpme_pkg::sat_add(rdat.ram, iram_r);
        end else begin
          new_cpu_nxt = bpme_pkg::clamp_sub(rdat.cpu, icpu_r);
          new_ram_nxt = bpme_pkg::clamp_sub(rdat.ram, iram_r);
        end
        old_fit_nxt     = rdat.fit;
        fit_req_vld     = 1'b1;
        fit_req_idx     = AW'(idx_r);
        fit_req_tag.cand = 1'b0;
        fit_req_tag.cpu  = new_cpu_nxt;
        fit_req_tag.ram  = new_ram_nxt;
        state_nxt       = ST_WAIT;
      end

      ST_WAIT: begin
        if (fit_res_vld) begin
          if (act_r == bpme_pkg::ACT_MOVE) begin
            fsrc_nxt    = fit_res;
            rd_cnt_nxt  = '0;
            res_cnt_nxt = '0;
            found_nxt   = 1'b0;
            state_nxt   = ST_SCAN;
          end else begin
            ram_we        = 1'b1;
            ram_waddr     = AW'(idx_r);
            ram_wdata.cpu = new_cpu_r;
            ram_wdata.ram = new_ram_r;
            ram_wdata.fit = fit_res;
            sum_nxt   = sum_r - SW'(old_fit_r) + SW'(fit_res);
            ovl_nxt   = ovl_r - CW'(old_fit_r != '0) + CW'(fit_res != '0);
            state_nxt = ST_FIN;
          end
        end
      end

      ST_SCAN: begin
        // Issue one read per cycle over the machines in use
        if (rd_cnt_r < n_act) begin
          ram_re     = 1'b1;
          ram_raddr  = rd_cnt_r[AW-1:0];
          rd_vld_nxt = 1'b1;
          rd_idx_nxt = rd_cnt_r[AW-1:0];
          rd_cnt_nxt = rd_cnt_r + NW'(1);
        end
        // Only non-overloaded machines other than the source qualify
        if (rd_vld_r) begin
          fit_req_vld      = 1'b1;
          fit_req_idx      = rd_idx_r;
          fit_req_tag.cand = (rd_idx_r != AW'(idx_r)) && (rdat.fit == '0);
          fit_req_tag.cpu  = bpme_pkg::sat_add(rdat.cpu, icpu_r);
          fit_req_tag.ram  = bpme_pkg::sat_add(rdat.ram, iram_r);
        end
        // The rest of the candidate total is common to all; compare the new fitness
        if (fit_res_vld) begin
          if (fit_res_tag.cand && (!found_r || (fit_res < best_fit_r))) begin
            found_nxt    = 1'b1;
            best_fit_nxt = fit_res;
            best_idx_nxt = fit_res_idx;
            best_cpu_nxt = fit_res_tag.cpu;
            best_ram_nxt = fit_res_tag.ram;
          end
          res_cnt_nxt = res_cnt_r + NW'(1);
          if (res_cnt_r == n_act - NW'(1)) begin
            state_nxt = ST_DECIDE;
          end
        end
      end

      ST_DECIDE: begin
        // Apply only if the new total beats the current one
        if (found_r && (({1'b0, fsrc_r} + {1'b0, best_fit_r}) < {1'b0, old_fit_r})) begin
          state_nxt = ST_WR_SRC;
        end else begin
          state_nxt = ST_FIN;
        end
      end

      ST_WR_SRC: begin
        ram_we        = 1'b1;
        ram_waddr     = AW'(idx_r);
        ram_wdata.cpu = new_cpu_r;
        ram_wdata.ram = new_ram_r;
        ram_wdata.fit = fsrc_r;
        sum_nxt   = sum_r - SW'(old_fit_r) + SW'(fsrc_r);
        ovl_nxt   = ovl_r - CW'(old_fit_r != '0) + CW'(fsrc_r != '0);
        state_nxt = ST_WR_DST;
      end

      ST_WR_DST: begin
        ram_we        = 1'b1;
        ram_waddr     = best_idx_r;
        ram_wdata.cpu = best_cpu_r;
        ram_wdata.ram = best_ram_r;
        ram_wdata.fit = best_fit_r;
        sum_nxt   = sum_r + SW'(best_fit_r);
        ovl_nxt   = ovl_r + CW'(best_fit_r != '0);
        moved_nxt = 1'b1;
        dest_nxt  = bpme_pkg::IDX_W'(best_idx_r);
        state_nxt = ST_FIN;
      end

      ST_FIN: begin
        // Hold until the output register is free
        if (!out_vld_r || out_tready) begin
          out_vld_nxt   = 1'b1;
          out_moved_nxt = moved_r;
          out_dest_nxt  = dest_r;
          out_sum_nxt   = (sum_ext > SXW'(bpme_pkg::SUM_MAX)) ? bpme_pkg::SUM_MAX
                                                              : sum_ext[45:0];
          out_ovl_nxt   = (ovl_ext > CXW'(bpme_pkg::COUNT_MAX)) ? bpme_pkg::COUNT_MAX
                                                                : ovl_ext[6:0];
          state_nxt     = ST_IDLE;
        end
      end

      ST_SWEEP: begin
        // Recompute every fitness from stored usage, sum those in use
        if (rd_cnt_r < NW'(MACHINE_SLOTS)) begin
          ram_re     = 1'b1;
          ram_raddr  = rd_cnt_r[AW-1:0];
          rd_vld_nxt = 1'b1;
          rd_idx_nxt = rd_cnt_r[AW-1:0];
          rd_cnt_nxt = rd_cnt_r + NW'(1);
        end
        if (rd_vld_r) begin
          fit_req_vld      = 1'b1;
          fit_req_idx      = rd_idx_r;
          fit_req_tag.cand = NW'(rd_idx_r) < n_act;
          fit_req_tag.cpu  = rdat.cpu;
          fit_req_tag.ram  = rdat.ram;
        end
        if (fit_res_vld) begin
          ram_we        = 1'b1;
          ram_waddr     = fit_res_idx;
          ram_wdata.cpu = fit_res_tag.cpu;
          ram_wdata.ram = fit_res_tag.ram;
          ram_wdata.fit = fit_res;
          if (fit_res_tag.cand) begin
            sum_nxt = sum_r + SW'(fit_res);
            ovl_nxt = ovl_r + CW'(fit_res != '0);
          end
          res_cnt_nxt = res_cnt_r + NW'(1);
          if (res_cnt_r == NW'(MACHINE_SLOTS - 1)) begin
            state_nxt = ST_IDLE;
          end
        end
      end

      default: begin
        state_nxt = ST_IDLE;
      end
    endcase

    // Register writes; usage is all zero during the clearing pass, so no refresh then
    if (cfg_hit) begin
      case (cfg_index)
        bpme_pkg::REG_MACHINE_COUNT: mcount_nxt       = cfg_wdata[6:0];
        bpme_pkg::REG_FIRST_TYPE:    cap_nxt.first_type = cfg_wdata[6:0];
        bpme_pkg::REG_CPU_CAP_A:     cap_nxt.cpu_a    = cfg_wdata;
        bpme_pkg::REG_RAM_CAP_A:     cap_nxt.ram_a    = cfg_wdata;
        bpme_pkg::REG_CPU_CAP_B:     cap_nxt.cpu_b    = cfg_wdata;
        bpme_pkg::REG_RAM_CAP_B:     cap_nxt.ram_b    = cfg_wdata;
        default: ;
      endcase
      if (state_r == ST_CLEAR) begin
        pend_nxt = 1'b0;
      end else if ((state_r == ST_SWEEP) || ((state_r == ST_IDLE) && !accept)) begin
        // Restart the refresh pass from the first slot
        pend_nxt    = 1'b0;
        rd_cnt_nxt  = '0;
        res_cnt_nxt = '0;
        rd_vld_nxt  = 1'b0;
        sum_nxt     = '0;
        ovl_nxt     = '0;
        fit_flush   = 1'b1;
        ram_we      = 1'b0;
        state_nxt   = ST_SWEEP;
      end else begin
        pend_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r          <= ST_CLEAR;
      mcount_r         <= 7'd64;
      cap_r.first_type <= 7'd64;
      cap_r.cpu_a      <= '0;
      cap_r.ram_a      <= '0;
      cap_r.cpu_b      <= '0;
      cap_r.ram_b      <= '0;
      pend_r           <= 1'b0;
      rd_cnt_r         <= '0;
      res_cnt_r        <= '0;
      rd_vld_r         <= 1'b0;
      found_r          <= 1'b0;
      sum_r            <= '0;
      ovl_r            <= '0;
      moved_r          <= 1'b0;
      out_vld_r        <= 1'b0;
    end else begin
      state_r   <= state_nxt;
      mcount_r  <= mcount_nxt;
      cap_r     <= cap_nxt;
      pend_r    <= pend_nxt;
      rd_cnt_r  <= rd_cnt_nxt;
      res_cnt_r <= res_cnt_nxt;
      rd_vld_r  <= rd_vld_nxt;
      found_r   <= found_nxt;
      sum_r     <= sum_nxt;
      ovl_r     <= ovl_nxt;
      moved_r   <= moved_nxt;
      out_vld_r <= out_vld_nxt;
    end
    act_r       <= act_nxt;
    idx_r       <= idx_nxt;
    icpu_r      <= icpu_nxt;
    iram_r      <= iram_nxt;
    new_cpu_r   <= new_cpu_nxt;
    new_ram_r   <= new_ram_nxt;
    old_fit_r   <= old_fit_nxt;
    fsrc_r      <= fsrc_nxt;
    rd_idx_r    <= rd_idx_nxt;
    best_fit_r  <= best_fit_nxt;
    best_idx_r  <= best_idx_nxt;
    best_cpu_r  <= best_cpu_nxt;
    best_ram_r  <= best_ram_nxt;
    dest_r      <= dest_nxt;
    out_moved_r <= out_moved_nxt;
    out_dest_r  <= out_dest_nxt;
    out_sum_r   <= out_sum_nxt;
    out_ovl_r   <= out_ovl_nxt;
  end

  assign out_tvalid = out_vld_r;
  assign out_tuser  = out_moved_r;
  assign out_tdata  = {5'b0, out_ovl_r, out_sum_r, out_dest_r};

endmodule

@@ sv/bpme_ram.sv @@
// Generic simple dual-port RAM: one write port, one read port, registered read.
// No dependencies.
module bpme_ram #(
  parameter int WIDTH = 80,
  parameter int DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem_r[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

@@ sv/bpme_fit_unit.sv @@
// Three-stage machine fitness pipeline: input register, excess over capacity,
// product and selection. Depends on bpme_pkg.
module bpme_fit_unit #(
  parameter int AW = 6
) (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            flush,
  input  bpme_pkg::cap_t                  cap,
  input  logic                            req_vld,
  input  logic [AW-1:0]                   req_idx,
  input  bpme_pkg::fit_tag_t              req_tag,
  output logic                            res_vld,
  output logic [AW-1:0]                   res_idx,
  output bpme_pkg::fit_tag_t              res_tag,
  output logic [bpme_pkg::FIT_W-1:0]      res_fit
);

  localparam int TW = (AW > bpme_pkg::CNT_CFG_W) ? AW : bpme_pkg::CNT_CFG_W;

  logic                               vld0_r, vld1_r, vld2_r;
  logic [AW-1:0]                      idx0_r, idx1_r, idx2_r;
  bpme_pkg::fit_tag_t                 tag0_r, tag1_r, tag2_r;
  logic [bpme_pkg::USAGE_W-1:0]       ce1_r, re1_r;
  logic [bpme_pkg::FIT_W-1:0]         fit2_r;

  logic                               type_a;
  logic [bpme_pkg::USAGE_W-1:0]       ccap, rcap, ce_nxt, re_nxt;
  logic [bpme_pkg::FIT_W-1:0]         prod, fit_nxt;

  // Stage 1: excess of each resource over the machine type's capacity
  always_comb begin
    type_a = TW'(idx0_r) < TW'(cap.first_type);
    ccap   = bpme_pkg::USAGE_W'(type_a ? cap.cpu_a : cap.cpu_b);
    rcap   = bpme_pkg::USAGE_W'(type_a ? cap.ram_a : cap.ram_b);
    ce_nxt = (tag0_r.cpu > ccap) ? (tag0_r.cpu - ccap) : '0;
    re_nxt = (tag0_r.ram > rcap) ? (tag0_r.ram - rcap) : '0;
  end

  // Stage 2: single excess, or the product when both are over
  assign prod = ce1_r * re1_r;

  always_comb begin
    if (ce1_r == '0) begin
      fit_nxt = bpme_pkg::FIT_W'(re1_r);
    end else if (re1_r == '0) begin
      fit_nxt = bpme_pkg::FIT_W'(ce1_r);
    end else begin
      fit_nxt = prod;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n || flush) begin
      vld0_r <= 1'b0;
      vld1_r <= 1'b0;
      vld2_r <= 1'b0;
    end else begin
      vld0_r <= req_vld;
      vld1_r <= vld0_r;
      vld2_r <= vld1_r;
    end
    idx0_r <= req_idx;
    tag0_r <= req_tag;
    idx1_r <= idx0_r;
    tag1_r <= tag0_r;
    ce1_r  <= ce_nxt;
    re1_r  <= re_nxt;
    idx2_r <= idx1_r;
    tag2_r <= tag1_r;
    fit2_r <= fit_nxt;
  end

  assign res_vld = vld2_r;
  assign res_idx = idx2_r;
  assign res_tag = tag2_r;
  assign res_fit = fit2_r;

endmodule

@@ sv/bpme_checker.sv @@
// Port-level checks for the bin-packing move evaluator, bound to the top level.
// Depends only on the top level's ports.
module bpme_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        in_tvalid,
  input logic        in_tready,
  input logic        out_tvalid,
  input logic        out_tready,
  input logic [63:0] out_tdata,
  input logic        out_tuser
);

  // Hold a stalled result
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata) && $stable(out_tuser))
    else $error("result changed or dropped while stalled");

  // Request port not ready right after reset, as the clearing pass begins
  a_reset_busy: assert property (@(posedge clk)
    !rst_n |=> !in_tready)
    else $error("request port ready right after reset");

  // One request at a time: ready drops after every taken request
  a_one_at_a_time: assert property (@(posedge clk) disable iff (!rst_n)
    in_tvalid && in_tready |=> !in_tready)
    else $error("request taken while another is in progress");

  // No move reported means no destination
  a_dest_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tuser |-> out_tdata[5:0] == 6'd0)
    else $error("destination set without a move");

  // Zero total and zero overloaded count go together
  a_total_count: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> ((out_tdata[51:6] == 46'd0) == (out_tdata[58:52] == 7'd0)))
    else $error("total fitness and overloaded count disagree");

endmodule

bind bin_packing_move_evaluator bpme_checker u_bpme_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .in_tvalid  (in_tvalid),
  .in_tready  (in_tready),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata),
  .out_tuser  (out_tuser)
);

@@ test/bin_packing_move_evaluator_tb.sv @@
`timescale 1ns / 1ps
// Self-checking bench for bin_packing_move_evaluator: drives place/remove/move requests
// and register writes, predicts every result in-bench. Depends on bpme_pkg and the RTL.
module bin_packing_move_evaluator_tb;
  import bpme_pkg::*;

  localparam int SLOTS         = 64;
  localparam int CYCLE_LIMIT   = 600000;
  // pause that covers a refresh pass after a write and the drain of a move
  localparam int SETTLE_CYCLES = SLOTS + 16;
  localparam logic [63:0] FIT_CEIL = 64'h00FF_FFFF_FFFF;
  localparam logic [63:0] SUM_CEIL = 64'h3FFF_FFFF_FFFF;

  typedef struct {
    logic                 moved;
    logic [IDX_W-1:0]     dest;
    logic [OUT_SUM_W-1:0] total;
    logic [OUT_CNT_W-1:0] over;
  } outcome_t;

  logic        clk;
  logic        rst_n;
  logic        in_tvalid;
  logic        in_tready;
  logic [39:0] in_tdata;   // machine_index[5:0], item_cpu[21:6], item_ram[37:22]
  logic [1:0]  in_tuser;   // action[1:0]
  logic        out_tvalid;
  logic        out_tready;
  logic [63:0] out_tdata;  // dest_machine[5:0], total_fitness[51:6], overloaded_count[58:52]
  logic        out_tuser;  // moved[0]
  logic        cfg_we;
  logic [2:0]  cfg_index;
  logic [15:0] cfg_wdata;

  bin_packing_move_evaluator uut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser),
    .cfg_we     (cfg_we),
    .cfg_index  (cfg_index),
    .cfg_wdata  (cfg_wdata)
  );

  // Machine table as the block should hold it
  logic [USAGE_W-1:0]   cpu_used [SLOTS];
  logic [USAGE_W-1:0]   ram_used [SLOTS];
  logic [63:0]          overload_fit [SLOTS];
  logic [CNT_CFG_W-1:0] machines_cfg;
  logic [CNT_CFG_W-1:0] type_a_cfg;
  logic [CAP_W-1:0]     cpu_cap_a;
  logic [CAP_W-1:0]     ram_cap_a;
  logic [CAP_W-1:0]     cpu_cap_b;
  logic [CAP_W-1:0]     ram_cap_b;

  outcome_t pending_outcomes[$];

  int errors;
  int sent_count;
  int moves_applied;
  int cfg_writes;
  int cycle_count;
  int hold_cycles;
  int stall_left;
  int calm_left;
  bit quiet;

  // ---------------------------------------------------------------------------
  // Predictor
  // ---------------------------------------------------------------------------

  // Slots beyond the table act as the table size
  function automatic int unsigned machines_in_use();
    return (machines_cfg > SLOTS) ? SLOTS : int'(machines_cfg);
  endfunction

  // Excess of the one resource over capacity, or the product when both are over
  function automatic logic [63:0] overload_of(int unsigned m, logic [USAGE_W-1:0] cpu,
                                              logic [USAGE_W-1:0] ram);
    logic [CAP_W-1:0] ccap;
    logic [CAP_W-1:0] rcap;
    logic [63:0]      ce;
    logic [63:0]      re;
    logic [63:0]      prod;
    ccap = (m < type_a_cfg) ? cpu_cap_a : cpu_cap_b;
    rcap = (m < type_a_cfg) ? ram_cap_a : ram_cap_b;
    ce = 0;
    re = 0;
    if (cpu > ccap) ce = cpu - ccap;
    if (ram > rcap) re = ram - rcap;
    if (ce == 0) return re;
    if (re == 0) return ce;
    prod = ce * re;
    return (prod > FIT_CEIL) ? FIT_CEIL : prod;
  endfunction

  function automatic logic [USAGE_W-1:0] grow(logic [USAGE_W-1:0] u, logic [DEM_W-1:0] d);
    logic [USAGE_W:0] s;
    s = u + d;
    return (s > USAGE_MAX) ? USAGE_MAX : s[USAGE_W-1:0];
  endfunction

  function automatic logic [USAGE_W-1:0] shrink(logic [USAGE_W-1:0] u, logic [DEM_W-1:0] d);
    return (u > d) ? u - d : '0;
  endfunction

  // Unsaturated sum over the machines in use
  function automatic logic [63:0] exact_sum();
    logic [63:0] s;
    s = 0;
    for (int unsigned m = 0; m < machines_in_use(); m++) s += overload_fit[m];
    return s;
  endfunction

  function automatic void refresh_all_fitness();
    for (int unsigned m = 0; m < SLOTS; m++)
      overload_fit[m] = overload_of(m, cpu_used[m], ram_used[m]);
  endfunction

  // Apply one request to the table and return the result it must produce
  function automatic outcome_t evaluate_request(action_t act, logic [IDX_W-1:0] src,
                                                logic [DEM_W-1:0] dc, logic [DEM_W-1:0] dr);
    outcome_t           res;
    int unsigned        n;
    int unsigned        dest;
    int unsigned        over;
    logic [63:0]        total;
    logic [63:0]        best;
    logic [63:0]        cand;
    logic [63:0]        fsrc;
    logic [63:0]        s;
    logic [USAGE_W-1:0] new_cpu;
    logic [USAGE_W-1:0] new_ram;
    logic               found;
    res.moved = 1'b0;
    res.dest  = '0;
    n = machines_in_use();
    if (src < n) begin
      case (act)
        ACT_PLACE: begin
          cpu_used[src] = grow(cpu_used[src], dc);
          ram_used[src] = grow(ram_used[src], dr);
          overload_fit[src] = overload_of(src, cpu_used[src], ram_used[src]);
        end
        ACT_REMOVE: begin
          cpu_used[src] = shrink(cpu_used[src], dc);
          ram_used[src] = shrink(ram_used[src], dr);
          overload_fit[src] = overload_of(src, cpu_used[src], ram_used[src]);
        end
        ACT_MOVE: begin
          total   = exact_sum();
          new_cpu = shrink(cpu_used[src], dc);
          new_ram = shrink(ram_used[src], dr);
          fsrc    = overload_of(src, new_cpu, new_ram);
          found   = 1'b0;
          best    = 0;
          dest    = 0;
          // only zero-fitness machines other than the source qualify; first lowest wins
          for (int unsigned m = 0; m < n; m++) begin
            if (m != src && overload_fit[m] == 0) begin
              cand = total - overload_fit[src] - overload_fit[m] + fsrc
                   + overload_of(m, grow(cpu_used[m], dc), grow(ram_used[m], dr));
              if (!found || cand < best) begin
                found = 1'b1;
                best  = cand;
                dest  = m;
              end
            end
          end
          if (found && best < total) begin
            cpu_used[src]      = new_cpu;
            ram_used[src]      = new_ram;
            cpu_used[dest]     = grow(cpu_used[dest], dc);
            ram_used[dest]     = grow(ram_used[dest], dr);
            overload_fit[src]  = fsrc;
            overload_fit[dest] = overload_of(dest, cpu_used[dest], ram_used[dest]);
            res.moved = 1'b1;
            res.dest  = dest[IDX_W-1:0];
          end
        end
        default: ;
      endcase
    end
    s = exact_sum();
    res.total = (s > SUM_CEIL) ? SUM_CEIL[OUT_SUM_W-1:0] : s[OUT_SUM_W-1:0];
    over = 0;
    for (int unsigned m = 0; m < n; m++)
      if (overload_fit[m] != 0 && over < COUNT_MAX) over++;
    res.over = over[OUT_CNT_W-1:0];
    return res;
  endfunction

  // ---------------------------------------------------------------------------
  // Clock, timeout, result checking
  // ---------------------------------------------------------------------------

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("Timeout after %0d cycles, %0d results outstanding", cycle_count,
               pending_outcomes.size());
      $display("FAIL bin_packing_move_evaluator");
      $finish;
    end
  end

  task automatic report_mismatch(string what, logic [63:0] got, logic [63:0] want);
    errors++;
    if (errors <= 50)
      $display("ERROR @%0t %s: got %0d expected %0d", $time, what, got, want);
  endtask

  // Compare each result taken against the oldest prediction
  always @(posedge clk) begin : check_results
    outcome_t want;
    if (rst_n && out_tvalid && out_tready) begin
      if (pending_outcomes.size() == 0) begin
        report_mismatch("result with no request pending", out_tdata, 0);
      end else begin
        want = pending_outcomes.pop_front();
        if (out_tuser !== want.moved) report_mismatch("moved", out_tuser, want.moved);
        if (out_tdata[5:0] !== want.dest)
          report_mismatch("dest_machine", out_tdata[5:0], want.dest);
        if (out_tdata[51:6] !== want.total)
          report_mismatch("total_fitness", out_tdata[51:6], want.total);
        if (out_tdata[58:52] !== want.over)
          report_mismatch("overloaded_count", out_tdata[58:52], want.over);
        if (want.moved) moves_applied++;
      end
    end
  end

  // Result-side ready: random stalls, calm stretches, and a long hold-off on request
  initial begin
    out_tready = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_cycles > 0) begin
        out_tready = 1'b0;
        hold_cycles--;
      end else if (quiet || calm_left > 0) begin
        out_tready = 1'b1;
        if (calm_left > 0) calm_left--;
      end else if (stall_left > 0) begin
        out_tready = 1'b0;
        stall_left--;
      end else begin
        out_tready = 1'b1;
        if ($urandom_range(0, 7) == 0) stall_left = $urandom_range(1, 8);
        else if ($urandom_range(0, 60) == 0) calm_left = 120;
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Driving helpers
  // ---------------------------------------------------------------------------

  // Offer one request, hold it until taken, then queue its predicted result
  task automatic send_request(action_t act, logic [IDX_W-1:0] idx, logic [DEM_W-1:0] dc,
                              logic [DEM_W-1:0] dr);
    int unsigned gap;
    @(negedge clk);
    if (!quiet && $urandom_range(0, 5) == 0) begin
      gap = $urandom_range(1, 8);
      in_tvalid = 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_tvalid = 1'b1;
    in_tuser  = act;
    in_tdata  = {2'b00, dr, dc, idx};
    do @(posedge clk); while (!in_tready);
    pending_outcomes.push_back(evaluate_request(act, idx, dc, dr));
    sent_count++;
  endtask

  // Drop valid and wait until every predicted result has come back
  task automatic wait_for_results();
    @(negedge clk);
    in_tvalid = 1'b0;
    while (pending_outcomes.size() != 0) @(posedge clk);
  endtask

  // Registers change only with the block idle; the pause covers a prior refresh pass
  task automatic write_register(logic [CFG_IDX_W-1:0] idx, logic [15:0] value);
    wait_for_results();
    repeat (SETTLE_CYCLES) @(negedge clk);
    cfg_we    = 1'b1;
    cfg_index = idx;
    cfg_wdata = value;
    @(negedge clk);
    cfg_we = 1'b0;
    case (idx)
      REG_MACHINE_COUNT: machines_cfg = value[CNT_CFG_W-1:0];
      REG_FIRST_TYPE:    type_a_cfg   = value[CNT_CFG_W-1:0];
      REG_CPU_CAP_A:     cpu_cap_a    = value;
      REG_RAM_CAP_A:     ram_cap_a    = value;
      REG_CPU_CAP_B:     cpu_cap_b    = value;
      REG_RAM_CAP_B:     ram_cap_b    = value;
      default: ;
    endcase
    // every write makes the block recompute all fitness values from stored usage
    refresh_all_fitness();
    cfg_writes++;
  endtask

  task automatic configure(int count, int first, int ca, int ra, int cb, int rb);
    write_register(REG_MACHINE_COUNT, count);
    write_register(REG_FIRST_TYPE, first);
    write_register(REG_CPU_CAP_A, ca);
    write_register(REG_RAM_CAP_A, ra);
    write_register(REG_CPU_CAP_B, cb);
    write_register(REG_RAM_CAP_B, rb);
  endtask

  // Mostly demands on the scale of the capacity, so machines tip over and recover
  function automatic logic [DEM_W-1:0] pick_demand(logic [CAP_W-1:0] cap);
    int unsigned roll;
    int unsigned span;
    roll = $urandom_range(0, 19);
    span = (cap < 64) ? 64 : cap;
    if (roll == 0) return '1;
    if (roll == 1) return '0;
    if (roll < 4) return $urandom;
    return $urandom_range(0, span * 2 / 3);
  endfunction

  task automatic random_request();
    int unsigned      n;
    int unsigned      roll;
    action_t          act;
    logic [IDX_W-1:0] idx;
    n = machines_in_use();
    roll = $urandom_range(0, 99);
    if (roll < 40) act = ACT_PLACE;
    else if (roll < 65) act = ACT_REMOVE;
    else if (roll < 95) act = ACT_MOVE;
    else act = ACT_NONE;
    // a few requests aim at indexes outside the machines in use
    if (n > 0 && $urandom_range(0, 9) != 0) idx = $urandom_range(0, n - 1);
    else idx = $urandom;
    send_request(act, idx, pick_demand(cpu_cap_a), pick_demand(ram_cap_a));
  endtask

  task automatic random_configure();
    int count;
    int first;
    int caps[4];
    case ($urandom_range(0, 5))
      0: count = 1;
      1: count = 2;
      2: count = 64;
      3: count = 127;
      default: count = $urandom_range(3, 64);
    endcase
    case ($urandom_range(0, 3))
      0: first = 0;
      1: first = 64;
      2: first = 127;
      default: first = $urandom_range(0, (count > 64) ? 64 : count);
    endcase
    foreach (caps[k]) begin
      case ($urandom_range(0, 9))
        0: caps[k] = 0;
        1: caps[k] = 65535;
        default: caps[k] = $urandom_range(100, 3000);
      endcase
    end
    configure(count, first, caps[0], caps[1], caps[2], caps[3]);
  endtask

  // ---------------------------------------------------------------------------
  // Tests
  // ---------------------------------------------------------------------------

  // Hand-picked requests: each fitness form, clamps, unused slots, move outcomes
  task automatic test_directed_cases();
    configure(8, 4, 100, 100, 50, 50);
    send_request(ACT_PLACE, 0, 60, 40);          // within capacity
    send_request(ACT_PLACE, 1, 150, 10);         // CPU over only
    send_request(ACT_PLACE, 2, 10, 130);         // RAM over only
    send_request(ACT_PLACE, 5, 70, 80);          // both over, second type
    send_request(ACT_NONE, 0, 16'hFFFF, 16'hFFFF);
    send_request(ACT_PLACE, 8, 500, 500);        // slot not in use
    send_request(ACT_MOVE, 8, 10, 10);           // move from slot not in use
    send_request(ACT_REMOVE, 3, 500, 500);       // clamp at zero
    send_request(ACT_MOVE, 1, 60, 0);            // move that pays off
    send_request(ACT_MOVE, 0, 10, 10);           // zero-fitness source, nothing better
    send_request(ACT_MOVE, 5, 16'hFFFF, 16'hFFFF); // every destination worse
    send_request(ACT_MOVE, 5, 30, 40);           // first of equal candidates wins
    send_request(ACT_PLACE, 0, 16'hFFFF, 16'hFFFF);
    send_request(ACT_REMOVE, 0, 16'hFFFF, 16'hFFFF);
    send_request(ACT_PLACE, 7, 0, 0);
  endtask

  // Register extremes: single machine, count above the table, zero count, one type only
  task automatic test_register_extremes();
    configure(1, 0, 0, 0, 0, 0);
    send_request(ACT_PLACE, 0, 10, 0);
    send_request(ACT_MOVE, 0, 5, 0);             // no other machine to take it
    repeat (3) random_request();
    configure(127, 127, 65535, 65535, 65535, 65535);
    send_request(ACT_PLACE, 63, 16'hFFFF, 16'hFFFF);
    repeat (4) random_request();
    configure(0, 64, 0, 0, 0, 0);
    send_request(ACT_MOVE, 0, 1, 1);
    repeat (3) random_request();
    configure(64, 0, 0, 0, 65535, 0);
    repeat (5) random_request();
    configure(2, 1, 300, 300, 100, 100);
    repeat (5) random_request();
  endtask

  // Pile maximum demands on one machine until usage saturates, then move some away
  task automatic test_usage_saturation();
    configure(4, 2, 1000, 1000, 1000, 1000);
    repeat (17) send_request(ACT_PLACE, 2, 16'hFFFF, 16'hFFFF);
    send_request(ACT_MOVE, 2, 16'hFFFF, 16'hFFFF);
    repeat (2) send_request(ACT_REMOVE, 2, 16'hFFFF, 16'hFFFF);
  endtask

  // Hold the result side off long enough that the block fills and stalls requests
  task automatic test_output_backpressure();
    wait_for_results();
    @(posedge clk);
    hold_cycles = 400;
    repeat (24) random_request();
  endtask

  task automatic test_random_phase(int items);
    random_configure();
    repeat (items) random_request();
  endtask

  // Closing stretch with no idling on either side
  task automatic test_steady_stream(int items);
    wait_for_results();
    quiet = 1'b1;
    random_configure();
    repeat (items) random_request();
  endtask

  // ---------------------------------------------------------------------------
  // Sequence
  // ---------------------------------------------------------------------------

  initial begin
    rst_n     = 1'b0;
    in_tvalid = 1'b0;
    in_tdata  = '0;
    in_tuser  = ACT_PLACE;
    cfg_we    = 1'b0;
    cfg_index = REG_MACHINE_COUNT;
    cfg_wdata = '0;
    quiet     = 1'b0;
    // state after reset
    machines_cfg = 64;
    type_a_cfg   = 64;
    cpu_cap_a    = 0;
    ram_cap_a    = 0;
    cpu_cap_b    = 0;
    ram_cap_b    = 0;
    for (int m = 0; m < SLOTS; m++) begin
      cpu_used[m]     = '0;
      ram_used[m]     = '0;
      overload_fit[m] = '0;
    end
    repeat (9) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    test_directed_cases();
    test_register_extremes();
    test_usage_saturation();
    test_output_backpressure();
    for (int p = 0; p < 10; p++) test_random_phase(58);
    test_steady_stream(90);

    wait_for_results();
    repeat (SETTLE_CYCLES) @(posedge clk);
    $display("Covered %0d requests, %0d moves applied, %0d register writes",
             sent_count, moves_applied, cfg_writes);
    $display("Mismatches: %0d", errors);
    if (errors == 0) begin
      $display("PASS bin_packing_move_evaluator");
    end else begin
      $display("FAIL bin_packing_move_evaluator");
    end
    $finish;
  end

endmodule

@@ sim.f @@
sv/bpme_pkg.sv
sv/bpme_ram.sv
sv/bpme_fit_unit.sv
sv/bin_packing_move_evaluator.sv
sv/bpme_checker.sv
test/bin_packing_move_evaluator_tb.sv
